@@ design/hdu_pkg.sv @@
// ----------------------------------------------------------------------------
// hdu_pkg: shared types and constants of the haversine distance unit
// Fixed-point constants, CORDIC arctangent table and pipeline depth.
// ----------------------------------------------------------------------------
package hdu_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int DIV_STEPS     = 2;
    localparam int SQRT_STEPS    = 31;
    localparam int PIPE_DEPTH    = 12 + DIV_STEPS + SQRT_STEPS + 2 * CORDIC_N;

    localparam logic signed [33:0] TURN_FULL     = 34'sd6039797760;
    localparam logic signed [33:0] TURN_HALF     = 34'sd3019898880;
    localparam logic signed [33:0] TURN_HALF_NEG = -34'sd3019898880;
    localparam logic signed [33:0] TURN_QTR      = 34'sd1509949440;
    localparam logic signed [33:0] TURN_QTR_NEG  = -34'sd1509949440;
    localparam logic [31:0]        PI_Q30        = 32'd3373259426;
    localparam logic [37:0]        DIV_RECIP     = 38'd195468733827;
    localparam logic signed [32:0] GAIN_Q30      = 33'sd652032874;
    localparam logic [30:0]        Q30_ONE       = 31'd1073741824;
    localparam logic [23:0]        DIAMETER_M    = 24'd12742000;
    localparam logic [24:0]        HALF_CIRC_M   = 25'd20015087;
    localparam logic [24:0]        THRESHOLD_RST = 25'd25000;

    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
        30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
        30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
    };

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } t_cordic;

    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] root;
        logic [61:0] rad;
    } t_sqrt;

    function automatic logic signed [31:0] clamp_unit(input logic signed [32:0] v);
        logic signed [32:0] lim;
        lim = {2'b00, Q30_ONE};
        if (v > lim) begin
            return 32'sd1073741824;
        end else if (v < -lim) begin
            return -32'sd1073741824;
        end
        return v[31:0];
    endfunction

endpackage

@@ design/hdu_div_cell.sv @@
// ----------------------------------------------------------------------------
// hdu_div_cell: division by 45 by reciprocal multiplication
// Forms four partial products with the scaled reciprocal, then sums them
// and keeps the quotient bits; two register stages.
// ----------------------------------------------------------------------------
module hdu_div_cell (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [36:0] i_x,
    output logic [30:0] o_q
);
    import hdu_pkg::*;

    logic [36:0] r_hh;
    logic [36:0] n_hh;
    logic [36:0] r_hl;
    logic [36:0] n_hl;
    logic [37:0] r_lh;
    logic [37:0] n_lh;
    logic [37:0] r_ll;
    logic [37:0] n_ll;
    logic [74:0] w_sum;
    logic [30:0] r_q;

    always_comb begin
        n_hh  = 37'(i_x[36:19]) * 37'(DIV_RECIP[37:19]);
        n_hl  = 37'(i_x[36:19]) * 37'(DIV_RECIP[18:0]);
        n_lh  = 38'(i_x[18:0]) * 38'(DIV_RECIP[37:19]);
        n_ll  = 38'(i_x[18:0]) * 38'(DIV_RECIP[18:0]);
        w_sum = (75'(r_hh) << 38) + (75'(r_hl) << 19) + (75'(r_lh) << 19) + 75'(r_ll);
    end

    // quotient is the product shifted down by 43
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= n_hh;
            r_hl <= n_hl;
            r_lh <= n_lh;
            r_ll <= n_ll;
            r_q  <= w_sum[73:43];
        end
    end

    assign o_q = r_q;

endmodule

@@ design/hdu_rot_cell.sv @@
// ----------------------------------------------------------------------------
// hdu_rot_cell: one rotation-mode CORDIC micro-rotation
// Turns the vector toward the residual angle by atan(2^-idx).
// ----------------------------------------------------------------------------
module hdu_rot_cell (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [4:0]       i_idx,
    input  hdu_pkg::t_cordic i_v,
    output hdu_pkg::t_cordic o_v
);
    import hdu_pkg::*;

    t_cordic            r_v;
    t_cordic            n_v;
    logic signed [32:0] w_xs;
    logic signed [32:0] w_ys;
    logic signed [32:0] w_at;

    always_comb begin
        w_xs = i_v.x >>> i_idx;
        w_ys = i_v.y >>> i_idx;
        w_at = $signed({3'b000, ATAN_Q30[i_idx]});
        if (!i_v.z[32]) begin
            n_v.x = i_v.x - w_ys;
            n_v.y = i_v.y + w_xs;
            n_v.z = i_v.z - w_at;
        end else begin
            n_v.x = i_v.x + w_ys;
            n_v.y = i_v.y - w_xs;
            n_v.z = i_v.z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
        end
    end

    assign o_v = r_v;

endmodule

@@ design/hdu_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// hdu_sqrt_cell: one digit step of the floor square root
// Brings down two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module hdu_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  hdu_pkg::t_sqrt i_v,
    output hdu_pkg::t_sqrt o_v
);
    import hdu_pkg::*;

    t_sqrt       r_v;
    t_sqrt       n_v;
    logic [33:0] w_t;
    logic [33:0] w_trial;
    logic        w_ge;

    always_comb begin
        w_t      = {i_v.rem, i_v.rad[61:60]};
        w_trial  = {1'b0, i_v.root, 2'b01};
        w_ge     = (w_t >= w_trial);
        n_v.rem  = w_ge ? 32'(w_t - w_trial) : w_t[31:0];
        n_v.root = {i_v.root[29:0], w_ge};
        n_v.rad  = {i_v.rad[59:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
        end
    end

    assign o_v = r_v;

endmodule

@@ design/hdu_vec_cell.sv @@
// ----------------------------------------------------------------------------
// hdu_vec_cell: one vectoring-mode CORDIC micro-rotation
// Drives y toward zero and accumulates the angle turned.
// ----------------------------------------------------------------------------
module hdu_vec_cell (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [4:0]       i_idx,
    input  hdu_pkg::t_cordic i_v,
    output hdu_pkg::t_cordic o_v
);
    import hdu_pkg::*;

    t_cordic            r_v;
    t_cordic            n_v;
    logic signed [32:0] w_xs;
    logic signed [32:0] w_ys;
    logic signed [32:0] w_at;

    always_comb begin
        w_xs = i_v.x >>> i_idx;
        w_ys = i_v.y >>> i_idx;
        w_at = $signed({3'b000, ATAN_Q30[i_idx]});
        if (!i_v.y[32]) begin
            n_v.x = i_v.x + w_ys;
            n_v.y = i_v.y - w_xs;
            n_v.z = i_v.z + w_at;
        end else begin
            n_v.x = i_v.x - w_ys;
            n_v.y = i_v.y + w_xs;
            n_v.z = i_v.z - w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
        end
    end

    assign o_v = r_v;

endmodule

@@ design/haversine_distance_unit.sv @@
// ----------------------------------------------------------------------------
// haversine_distance_unit: great-circle distance with arrival flag
// Haversine distance on a 6371 km sphere, built as chains of CORDIC,
// divider and square-root cells.
// ----------------------------------------------------------------------------
// Takes one coordinate pair per clock while the output is not stalled and
// returns one distance per pair, in order; the pipeline is made of the cell
// chains: a two-stage reciprocal divider for the degree-to-radian scaling,
// the rotation CORDIC for sine and cosine, a 31-step square root and the
// vectoring CORDIC for atan2. The whole pipeline advances together and holds
// while a result waits on the output.
module haversine_distance_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [127:0]  i_s_axis_tdata,   // lat_a[30:0] lon_a[62:31] lat_b[93:63] lon_b[125:94]
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [31:0]   o_m_axis_tdata,   // distance_m[24:0]
    output logic          o_m_axis_tuser,   // arrived[0]
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [24:0]   i_cfg_data        // arrival_threshold_m
);
    import hdu_pkg::*;

    localparam int NEG_LEN  = DIV_STEPS + 1;
    localparam int FLIP_LEN = DIV_STEPS + CORDIC_N + 2;

    logic                   w_en;
    logic [PIPE_DEPTH-1:0]  r_vld;
    logic [24:0]            r_thr;

    logic signed [30:0]     r_lat_a;
    logic signed [31:0]     r_lon_a;
    logic signed [30:0]     r_lat_b;
    logic signed [31:0]     r_lon_b;

    logic signed [32:0]     w_ang  [4];
    logic signed [32:0]     r_wrap [4];
    logic [30:0]            r_mag  [4];
    logic                   r_neg  [4];
    logic                   r_flip [4];
    logic [36:0]            r_q    [4];
    logic [NEG_LEN-1:0]     r_neg_line  [4];
    logic [FLIP_LEN-1:0]    r_flip_line [4];
    t_cordic                rot_v  [4][CORDIC_N+1];
    logic signed [31:0]     r_trig [4];

    logic [30:0]            r_hlat;
    logic [30:0]            r_hlon;
    logic signed [31:0]     r_prod;
    logic [30:0]            r_hlat2;
    logic signed [31:0]     r_t;
    logic [30:0]            r_a;
    logic [30:0]            w_b;
    logic signed [63:0]     w_m_lat;
    logic signed [63:0]     w_m_lon;
    logic signed [63:0]     w_m_prod;
    logic signed [63:0]     w_m_t;
    logic signed [32:0]     w_sum;

    t_sqrt                  sqy_v [SQRT_STEPS+1];
    t_sqrt                  sqx_v [SQRT_STEPS+1];
    t_cordic                vec_v [CORDIC_N+1];

    logic [30:0]            w_zc;
    logic [54:0]            r_d1;
    logic [55:0]            w_rnd;
    logic [24:0]            r_d2;
    logic [24:0]            r_dist;
    logic                   r_arrived;

    assign w_en            = !r_vld[PIPE_DEPTH-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_thr <= THRESHOLD_RST;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[PIPE_DEPTH-2:0], i_s_axis_tvalid};
            end
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lat_a <= i_s_axis_tdata[30:0];
            r_lon_a <= i_s_axis_tdata[62:31];
            r_lat_b <= i_s_axis_tdata[93:63];
            r_lon_b <= i_s_axis_tdata[125:94];
        end
    end

    always_comb begin
        w_ang[0] = 33'(r_lat_b) - 33'(r_lat_a);
        w_ang[1] = 33'(r_lon_b) - 33'(r_lon_a);
        w_ang[2] = 33'($signed({r_lat_a, 1'b0}));
        w_ang[3] = 33'($signed({r_lat_b, 1'b0}));
    end

    for (genvar p = 0; p < 4; p++) begin : g_path
        logic signed [33:0] w_a34;
        logic signed [33:0] w_wr;
        logic signed [33:0] w_r34;
        logic signed [33:0] w_m34;
        logic               w_neg;
        logic               w_flip;
        logic [62:0]        w_p;
        logic [30:0]        w_quo;

        always_comb begin
            w_a34 = 34'(w_ang[p]);
            priority if (w_a34 >= TURN_HALF) begin
                w_wr = w_a34 - TURN_FULL;
            end else if (w_a34 < TURN_HALF_NEG) begin
                w_wr = w_a34 + TURN_FULL;
            end else begin
                w_wr = w_a34;
            end

            w_r34 = 34'(r_wrap[p]);
            priority if (w_r34 > TURN_QTR) begin
                w_m34  = TURN_HALF - w_r34;
                w_neg  = 1'b0;
                w_flip = 1'b1;
            end else if (w_r34 < TURN_QTR_NEG) begin
                w_m34  = TURN_HALF + w_r34;
                w_neg  = 1'b1;
                w_flip = 1'b1;
            end else if (w_r34 < 0) begin
                w_m34  = -w_r34;
                w_neg  = 1'b1;
                w_flip = 1'b0;
            end else begin
                w_m34  = w_r34;
                w_neg  = 1'b0;
                w_flip = 1'b0;
            end

            w_p = 63'(r_mag[p]) * 63'(PI_Q30);
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_wrap[p]      <= w_wr[32:0];
                r_mag[p]       <= w_m34[30:0];
                r_neg[p]       <= w_neg;
                r_flip[p]      <= w_flip;
                r_q[p]         <= w_p[62:26];
                r_neg_line[p]  <= {r_neg_line[p][NEG_LEN-2:0], r_neg[p]};
                r_flip_line[p] <= {r_flip_line[p][FLIP_LEN-2:0], r_flip[p]};
            end
        end

        hdu_div_cell u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (r_q[p]),
            .o_q   (w_quo)
        );

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                rot_v[p][0].x <= GAIN_Q30;
                rot_v[p][0].y <= '0;
                rot_v[p][0].z <= r_neg_line[p][DIV_STEPS]
                                 ? -$signed({2'b00, w_quo})
                                 :  $signed({2'b00, w_quo});
            end
        end

        for (genvar k = 0; k < CORDIC_N; k++) begin : g_rot
            hdu_rot_cell u_rot (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_idx (5'(k)),
                .i_v   (rot_v[p][k]),
                .o_v   (rot_v[p][k+1])
            );
        end

        if (p < 2) begin : g_sin
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_trig[p] <= clamp_unit(rot_v[p][CORDIC_N].y);
                end
            end
        end else begin : g_cos
            logic signed [31:0] w_c;
            always_comb begin
                w_c = clamp_unit(rot_v[p][CORDIC_N].x);
            end
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_trig[p] <= r_flip_line[p][FLIP_LEN-1] ? -w_c : w_c;
                end
            end
        end
    end

    always_comb begin
        w_m_lat  = 64'(r_trig[0]) * 64'(r_trig[0]);
        w_m_lon  = 64'(r_trig[1]) * 64'(r_trig[1]);
        w_m_prod = 64'(r_trig[2]) * 64'(r_trig[3]);
        w_m_t    = 64'(r_prod) * $signed({33'd0, r_hlon});
        w_sum    = $signed({2'b00, r_hlat2}) + 33'(r_t);
        w_b      = Q30_ONE - r_a;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hlat  <= w_m_lat[60:30];
            r_hlon  <= w_m_lon[60:30];
            r_prod  <= w_m_prod[61:30];
            r_hlat2 <= r_hlat;
            r_t     <= w_m_t[61:30];
            priority if (w_sum < 0) begin
                r_a <= '0;
            end else if (w_sum > $signed({2'b00, Q30_ONE})) begin
                r_a <= Q30_ONE;
            end else begin
                r_a <= w_sum[30:0];
            end
        end
    end

    assign sqy_v[0] = '{rem: 32'd0, root: 31'd0, rad: {1'b0, r_a, 30'd0}};
    assign sqx_v[0] = '{rem: 32'd0, root: 31'd0, rad: {1'b0, w_b, 30'd0}};

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        hdu_sqrt_cell u_sqy (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_v   (sqy_v[k]),
            .o_v   (sqy_v[k+1])
        );
        hdu_sqrt_cell u_sqx (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_v   (sqx_v[k]),
            .o_v   (sqx_v[k+1])
        );
    end

    assign vec_v[0] = '{x: $signed({2'b00, sqx_v[SQRT_STEPS].root}),
                        y: $signed({2'b00, sqy_v[SQRT_STEPS].root}),
                        z: '0};

    for (genvar k = 0; k < CORDIC_N; k++) begin : g_vec
        hdu_vec_cell u_vec (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_idx (5'(k)),
            .i_v   (vec_v[k]),
            .o_v   (vec_v[k+1])
        );
    end

    always_comb begin
        w_zc  = vec_v[CORDIC_N].z[32] ? 31'd0 : vec_v[CORDIC_N].z[30:0];
        w_rnd = 56'(r_d1) + 56'(1 << 29);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1      <= 55'(DIAMETER_M) * 55'(w_zc);
            r_d2      <= (w_rnd[55:30] > 26'(HALF_CIRC_M)) ? HALF_CIRC_M : w_rnd[54:30];
            r_dist    <= r_d2;
            r_arrived <= (r_d2 <= r_thr);
        end
    end

    assign o_m_axis_tvalid = r_vld[PIPE_DEPTH-1];
    assign o_m_axis_tdata  = {7'd0, r_dist};
    assign o_m_axis_tuser  = r_arrived;

endmodule

@@ bench/haversine_distance_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance_unit_test: self-checking bench for the distance unit
// Drives coordinate pairs through the stream input with random gaps and
// output stalls. An in-bench fixed-point model of the haversine chain
// (CORDIC sine/cosine, floor roots, CORDIC atan2) predicts each distance
// and arrival flag, and every output beat is compared in order.
// ----------------------------------------------------------------------------
module haversine_distance_unit_test;
    import hdu_pkg::*;

    localparam longint FULL_T  = 64'sd6039797760;
    localparam longint HALF_T  = 64'sd3019898880;
    localparam longint QTR_T   = 64'sd1509949440;
    localparam longint PI30    = 64'sd3373259426;
    localparam longint ONE30   = 64'sd1073741824;
    localparam longint DIAM    = 64'sd12742000;
    localparam longint HALFC   = 64'sd20015087;
    localparam longint LAT_MAX = 64'sd754974720;
    localparam longint LON_MAX = 64'sd1509949440;
    localparam int     IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [24:0] dist_m;
        logic        arrived;
    } t_fix;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [31:0]  o_m_axis_tdata;
    logic         o_m_axis_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [24:0]  i_cfg_data = '0;

    t_fix        fix_q[$];
    logic [24:0] threshold;
    int          fail_cnt = 0;
    int          sent_cnt = 0;
    int          recv_cnt = 0;
    int          idle_cnt = 0;
    int          arrived_cnt = 0;
    bit          hold_sink = 1'b0;
    bit          done = 1'b0;

    haversine_distance_unit dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp1(longint v);
        if (v > ONE30) return ONE30;
        if (v < -ONE30) return -ONE30;
        return v;
    endfunction

    // angle in 2^-24 degree; returns {sin, cos} in Q30
    task automatic rot_sincos(input longint ang, output longint s, output longint c);
        longint r, z, x, y, xs, ys, mag;
        bit flip;
        r = ang % FULL_T;
        flip = 0;
        x = 64'sd652032874;
        y = 0;
        if (r >= HALF_T) r -= FULL_T;
        else if (r < -HALF_T) r += FULL_T;
        if (r > QTR_T) begin
            r = HALF_T - r;
            flip = 1;
        end else if (r < -QTR_T) begin
            r = -HALF_T - r;
            flip = 1;
        end
        mag = (r < 0) ? -r : r;
        z = (mag * PI30) / HALF_T;
        if (r < 0) z = -z;
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
            end else begin
                x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
            end
        end
        x = clamp1(x);
        s = clamp1(y);
        c = flip ? -x : x;
    endtask

    function automatic longint isqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    task automatic predict_distance(input logic [127:0] d, output t_fix f);
        longint la, oa, lb, ob, sl, so, ca, cb, nu, hl, ho, pr, a, x, y, z, xs, ys, dist_m;
        la = longint'($signed(d[30:0]));
        oa = longint'($signed(d[62:31]));
        lb = longint'($signed(d[93:63]));
        ob = longint'($signed(d[125:94]));
        rot_sincos(lb - la, sl, nu);
        rot_sincos(ob - oa, so, nu);
        rot_sincos(la * 2, nu, ca);
        rot_sincos(lb * 2, nu, cb);
        hl = (sl * sl) >>> 30;
        ho = (so * so) >>> 30;
        pr = fshift(ca * cb, 30);
        a = hl + fshift(pr * ho, 30);
        if (a < 0) a = 0;
        if (a > ONE30) a = ONE30;
        y = isqrt(longint'(a) << 30);
        x = isqrt(longint'(ONE30 - a) << 30);
        z = 0;
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
            end else begin
                x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
            end
        end
        if (z < 0) z = 0;
        dist_m = (DIAM * z + (64'sd1 <<< 29)) >>> 30;
        if (dist_m > HALFC) dist_m = HALFC;
        f.dist_m = dist_m[24:0];
        f.arrived = (dist_m[24:0] <= threshold);
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    task automatic send_pair(input longint la, input longint oa, input longint lb,
                             input longint ob, input bit no_gap = 0);
        logic [127:0] d;
        t_fix f;
        int g;
        d = '0;
        d[30:0] = la[30:0];
        d[62:31] = oa[31:0];
        d[93:63] = lb[30:0];
        d[125:94] = ob[31:0];
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= d;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_distance(d, f);
        fix_q.push_back(f);
        sent_cnt++;
    endtask

    task automatic end_burst();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        end_burst();
        while (fix_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [24:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        threshold = v;
    endtask

    function automatic longint rnd_span(longint lim);
        return longint'($urandom_range(0, 32'(2 * lim))) - lim;
    endfunction

    function automatic longint rnd_field(int w);
        longint v;
        v = longint'({$urandom, $urandom});
        return (w == 31) ? longint'($signed(v[30:0])) : longint'($signed(v[31:0]));
    endfunction

    task automatic test_directed();
        send_pair(0, 0, 0, 0);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_pair(0, -LON_MAX, 0, LON_MAX);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(0, 0, 0, 64'sd1509949440 + 1);
        send_pair(0, 0, 0, LON_MAX - 1);
        send_pair(-(64'sd1 << 30), -(64'sd1 << 31), (64'sd1 << 30) - 1, (64'sd1 << 31) - 1);
        send_pair((64'sd1 << 30) - 1, (64'sd1 << 31) - 1, -(64'sd1 << 30), -(64'sd1 << 31));
        send_pair(LAT_MAX, 0, LAT_MAX, LON_MAX);
        send_pair(LAT_MAX + 1000, 0, -LAT_MAX - 1000, 12345);
        send_pair(64'sd1000000000, 0, -64'sd1000000000, 0);
        send_pair(0, 0, 1, 0);
        send_pair(0, 0, 64'sd100000, 0);
        send_pair(64'sd400000000, 64'sd80000000, 64'sd400000000, 64'sd80100000);
        send_pair(0, 0, 0, 64'sd1509949440 * 2 / 3);
        send_pair(-1, -1, -1, -1);
        send_pair(64'sd419430400, 0, -64'sd419430400, LON_MAX);
        drain_results();
    endtask

    task automatic test_thresholds();
        logic [24:0] vals [5] = '{25'd0, 25'd25000, 25'd20015087, 25'h1FFFFFF, 25'd1000000};
        foreach (vals[k]) begin
            write_threshold(vals[k]);
            for (int n = 0; n < 12; n++)
                send_pair(rnd_span(LAT_MAX), rnd_span(LON_MAX), rnd_span(LAT_MAX),
                          rnd_span(LON_MAX));
            send_pair(0, 0, 0, 0);
            send_pair(0, 0, 0, LON_MAX);
            drain_results();
        end
        write_threshold(THRESHOLD_RST);
    endtask

    task automatic test_random(input int count);
        longint la, oa;
        for (int n = 0; n < count; n++) begin
            la = rnd_span(LAT_MAX);
            oa = rnd_span(LON_MAX);
            case ($urandom_range(0, 9))
                0: send_pair(rnd_field(31), rnd_field(32), rnd_field(31), rnd_field(32));
                1, 2: send_pair(la, oa, la + rnd_span(64'sd4000000),
                                oa + rnd_span(64'sd4000000));
                default: send_pair(la, oa, rnd_span(LAT_MAX), rnd_span(LON_MAX));
            endcase
            if (n % 400 == 399) begin
                drain_results();
                write_threshold(25'($urandom_range(0, 20015087)));
            end
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_sink = 1'b1;
                repeat (PIPE_DEPTH + 200) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            for (int n = 0; n < PIPE_DEPTH + 60; n++)
                send_pair(rnd_span(LAT_MAX), rnd_span(LON_MAX), rnd_span(LAT_MAX),
                          rnd_span(LON_MAX), 1);
        join
        drain_results();
    endtask

    // output side: random stalls, long hold when requested
    always @(posedge i_clk) begin
        if (hold_sink) i_m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 29) == 0) i_m_axis_tready <= 1'b0;
        else i_m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        t_fix f;
        if (o_m_axis_tvalid && i_m_axis_tready && i_rst_n) begin
            if (fix_q.size() == 0) begin
                $error("unexpected beat: distance_m %0d", o_m_axis_tdata[24:0]);
                fail_cnt++;
            end else begin
                f = fix_q.pop_front();
                recv_cnt++;
                if (f.arrived) arrived_cnt++;
                if (o_m_axis_tdata[24:0] !== f.dist_m) begin
                    $error("distance_m expected %0d actual %0d", f.dist_m,
                           o_m_axis_tdata[24:0]);
                    fail_cnt++;
                end
                if (o_m_axis_tuser !== f.arrived) begin
                    $error("arrived expected %0b actual %0b", f.arrived, o_m_axis_tuser);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > IDLE_LIMIT && !done) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        threshold = THRESHOLD_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_thresholds();
        test_backpressure();
        test_random(1710);
        done = 1'b1;
        if (fix_q.size() != 0) begin
            $error("%0d expected results never arrived", fix_q.size());
            fail_cnt++;
        end
        $display("sent %0d pairs, checked %0d distances (%0d flagged arrived)",
                 sent_cnt, recv_cnt, arrived_cnt);
        $display("covered field extremes, threshold settings and output back-pressure");
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
design/hdu_pkg.sv
design/hdu_div_cell.sv
design/hdu_rot_cell.sv
design/hdu_sqrt_cell.sv
design/hdu_vec_cell.sv
design/haversine_distance_unit.sv
bench/haversine_distance_unit_test.sv
